@@ rtl/core/btpf_pkg.sv @@
// Shared types and constants for the background tile pixel fetch block.
`timescale 1ns / 1ps

package btpf_pkg;

    // Screen and video memory geometry
    localparam int SCREEN_WIDTH       = 160;
    localparam int VIDEO_MEMORY_BYTES = 8192;
    localparam int VRAM_AW            = $clog2(VIDEO_MEMORY_BYTES);

    // Configuration register indexes
    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_SCROLL_Y = 2'd1;
    localparam logic [1:0] REG_SCROLL_X = 2'd2;
    localparam logic [1:0] REG_PALETTE  = 2'd3;

    // Reset values
    localparam logic [7:0] CONTROL_RESET = 8'h91;
    localparam logic [7:0] PALETTE_RESET = 8'hFC;

    // Control bits
    localparam int CTRL_BG_ENABLE = 0;
    localparam int CTRL_MAP_SEL   = 3;
    localparam int CTRL_TILE_MODE = 4;

    // Input item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // Tile maps live at 0x1800 / 0x1C00: top two address bits set
    localparam logic [1:0] MAP_REGION = 2'b11;

    // One access to the single-port video memory
    typedef struct packed {
        logic               we;
        logic               re;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } mem_req_t;

endpackage

@@ rtl/core/btpf_vram.sv @@
// Single-port 8 KiB video memory with registered read data.
`timescale 1ns / 1ps

module btpf_vram
(
    input  logic              clk,
    input  btpf_pkg::mem_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] mem [btpf_pkg::VIDEO_MEMORY_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        // read data holds until the next read
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/background_tile_pixel_fetch.sv @@
// Top level: background tile pixel fetch with its video memory and sequencer.
`timescale 1ns / 1ps

// Background tile pixel fetch. The block owns an 8 KiB video memory behind one
// single-port synchronous RAM. A write transfer (mode 0) stores write_data at
// vram_addr and returns nothing. A fetch transfer (mode 1) returns one
// background pixel for (line, column): the scroll offsets are added mod 256,
// the tile number is read from the map picked by control bit 3, then the low
// and high plane bytes of the tile row are read (control bit 4 picks unsigned
// tile addressing from 0 or signed addressing around 0x1000), and the 2-bit
// colour is mapped through the palette. A fetch issues one RAM access per
// step on the single port (map byte, low plane, high plane); its final step
// already accepts the next transfer, so back-to-back fetches overlap and
// writes run at one per cycle. With control bit 0 clear a fetch returns
// blank=1, shade=0 without touching memory. A fetch with column at or
// beyond the screen width is dropped with no result. Results leave through
// an output register, so a stalled consumer does not stop the memory work
// already in flight; the sequencer only holds in its final step when that
// register is still full. Configuration writes are taken at any cycle with
// cfg_write high and must only happen while idle. Video memory contents are
// undefined after reset until written; there is no clearing pass.

module background_tile_pixel_fetch
(
    input  logic       clk,
    input  logic       rst_n,

    // configuration write port
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    // input transfer channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [12:0] vram_addr,
    input  logic [7:0] write_data,
    input  logic [7:0] line,
    input  logic [7:0] column,

    // result transfer channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] shade,
    output logic       blank
);

    // Sequencer steps:
    //   IDLE  - waiting, port free
    //   TILE  - map byte comes back; issue low plane read
    //   LO    - low plane byte comes back; issue high plane read
    //   HI    - high plane byte comes back; finish pixel, may accept next
    //   BLANK - finish a disabled-background pixel, may accept next
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TILE,
        ST_LO,
        ST_HI,
        ST_BLANK
    } fsm_t;

    fsm_t state_reg, state_next;

    // configuration
    logic [7:0] control_reg, scroll_y_reg, scroll_x_reg, palette_reg;

    // per-item working state
    logic [2:0]  xfine_reg, xfine_next;
    logic [2:0]  yfine_reg, yfine_next;
    logic [11:0] row_addr_reg, row_addr_next;  // tile row address without bit 0
    logic        lo_bit_reg, lo_bit_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [1:0] shade_reg, shade_next;
    logic       blank_reg, blank_next;

    // memory port
    btpf_pkg::mem_req_t req;
    logic [7:0]         rdata;

    logic       finishing, slot_free, accept, on_screen;
    logic [7:0] y_pos, x_pos;
    logic [2:0] bit_sel;
    logic [1:0] colour;

    btpf_vram u_vram
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= btpf_pkg::CONTROL_RESET;
            scroll_y_reg <= '0;
            scroll_x_reg <= '0;
            palette_reg  <= btpf_pkg::PALETTE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                btpf_pkg::REG_CONTROL:  control_reg  <= cfg_data;
                btpf_pkg::REG_SCROLL_Y: scroll_y_reg <= cfg_data;
                btpf_pkg::REG_SCROLL_X: scroll_x_reg <= cfg_data;
                btpf_pkg::REG_PALETTE:  palette_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign finishing = (state_reg == ST_HI) || (state_reg == ST_BLANK);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || (finishing && slot_free);
    assign accept    = in_valid && in_ready;

    assign y_pos     = line + scroll_y_reg;     // wraps at 256
    assign x_pos     = column + scroll_x_reg;
    assign on_screen = {1'b0, column} < 9'(btpf_pkg::SCREEN_WIDTH);

    // pixel bit 7 is the leftmost
    assign bit_sel = 3'd7 - xfine_reg;
    assign colour  = {rdata[bit_sel], lo_bit_reg};

    always_comb
    begin
        state_next     = state_reg;
        xfine_next     = xfine_reg;
        yfine_next     = yfine_reg;
        row_addr_next  = row_addr_reg;
        lo_bit_next    = lo_bit_reg;
        out_valid_next = out_valid_reg;
        shade_next     = shade_reg;
        blank_next     = blank_reg;
        req            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_TILE:
            begin
                // rdata is the tile number; signed mode folds 0x1000 + s*16
                // into an inverted top bit
                row_addr_next = {(control_reg[btpf_pkg::CTRL_TILE_MODE] ? 1'b0 : ~rdata[7]),
                                 rdata, yfine_reg};
                req.re        = 1'b1;
                req.addr      = {row_addr_next, 1'b0};
                state_next    = ST_LO;
            end
            ST_LO:
            begin
                lo_bit_next = rdata[bit_sel];
                req.re      = 1'b1;
                req.addr    = {row_addr_reg, 1'b1};
                state_next  = ST_HI;
            end
            ST_HI:
            begin
                // stall here with read data held if the result slot is busy
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    blank_next     = 1'b0;
                    case (colour)
                        2'd0:    shade_next = palette_reg[1:0];
                        2'd1:    shade_next = palette_reg[3:2];
                        2'd2:    shade_next = palette_reg[5:4];
                        default: shade_next = palette_reg[7:6];
                    endcase
                    state_next = ST_IDLE;
                end
            end
            ST_BLANK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    blank_next     = 1'b1;
                    shade_next     = 2'd0;
                    state_next     = ST_IDLE;
                end
            end
            default: ;
        endcase

        // new transfer: only in IDLE or a finishing step, so the port is free
        if (accept)
        begin
            if (mode == btpf_pkg::MODE_WRITE)
            begin
                req.we     = 1'b1;
                req.addr   = vram_addr;
                req.wdata  = write_data;
                state_next = ST_IDLE;
            end
            else if (!on_screen)
            begin
                state_next = ST_IDLE;
            end
            else if (!control_reg[btpf_pkg::CTRL_BG_ENABLE])
            begin
                state_next = ST_BLANK;
            end
            else
            begin
                req.re     = 1'b1;
                req.addr   = {btpf_pkg::MAP_REGION, control_reg[btpf_pkg::CTRL_MAP_SEL],
                              y_pos[7:3], x_pos[7:3]};
                xfine_next = x_pos[2:0];
                yfine_next = y_pos[2:0];
                state_next = ST_TILE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        xfine_reg    <= xfine_next;
        yfine_reg    <= yfine_next;
        row_addr_reg <= row_addr_next;
        lo_bit_reg   <= lo_bit_next;
        shade_reg    <= shade_next;
        blank_reg    <= blank_next;
    end

    assign out_valid = out_valid_reg;
    assign shade     = shade_reg;
    assign blank     = blank_reg;

endmodule
